>>> design/sfa_pkg.sv
// shared types, widths and register indexes of the substring search block
package sfa_pkg;

   // field widths
   localparam int BYTE_W     = 8;
   localparam int POS_W      = 31;
   localparam int COUNT_W    = 16;
   localparam int LEN_W      = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;

   // stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_HIGH   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_LENGTH = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_IGNORE_CASE    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_POSITION = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_MATCH_LIMIT    = 3'd5;

   // one result item
   typedef struct packed {
      logic               found;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] count;
      logic               done;
   } rsp_type;

endpackage

>>> design/substring_find_all.sv
// top level of the streaming substring search: config registers, cell row, counters
// a result enters the output buffer at the input transfer of the byte that causes it
// throughput: one byte per cycle when req_tready is high; one compare pass across the row
// a two-entry output buffer keeps input flowing while one result waits to be taken
// reset (synchronous, active high) restores register defaults and clears counters
// window bytes are not cleared; only bytes already seen in the text are ever compared
module substring_find_all #(
   parameter int PATTERN_MAX = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: text_byte[7:0]
   input  logic [sfa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: first_of_text
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rsp_tdata: match_position[30:0], matches_so_far[46:31], zero pad[47]
   output logic [sfa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tuser: match_found
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [sfa_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sfa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sfa_pkg::*;

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

   // configuration registers
   logic [CSR_DATA_W-1:0] pattern_low_ff;
   logic [CSR_DATA_W-1:0] pattern_high_ff;
   logic [LEN_W-1:0]      pattern_length_ff;
   logic                  ignore_case_ff;
   logic [POS_W-1:0]      start_position_ff;
   logic [COUNT_W-1:0]    match_limit_ff;

   // text state
   logic [LEN_W-1:0]   bytes_seen_ff, bytes_seen_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [COUNT_W-1:0] counter_ff, counter_in;

   logic                    accept;
   logic                    space_ok;
   logic [2*CSR_DATA_W-1:0] pat_vec;
   logic [LEN_W-1:0]        len_eff;
   logic [LEN_W-1:0]        seen_cur;
   logic [LEN_W-1:0]        seen;
   logic [POS_W-1:0]        pos_cur;
   logic [COUNT_W-1:0]      count_cur;
   logic [COUNT_W-1:0]      count_new;
   logic [POS_W-1:0]        match_pos;
   logic                    all_eq;
   logic                    hit;
   logic                    emit;
   rsp_type                 result;
   rsp_type                 out_data;

   logic [BYTE_W-1:0] chain    [PATTERN_MAX+1];
   logic [BYTE_W-1:0] pat_algn [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] use_en;
   logic [PATTERN_MAX-1:0] eq;

   assign accept = req_tvalid && req_tready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= LEN_W'(1);
         ignore_case_ff    <= 1'b0;
         start_position_ff <= '0;
         match_limit_ff    <= '1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_wdata;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_IGNORE_CASE:    ignore_case_ff    <= csr_wdata[0];
            CSR_START_POSITION: start_position_ff <= csr_wdata[POS_W-1:0];
            CSR_MATCH_LIMIT:    match_limit_ff    <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the length and line the pattern up with the cells, last byte at cell 0
   assign pat_vec = {pattern_high_ff, pattern_low_ff};
   assign len_eff = (pattern_length_ff > LEN_MAX) ? LEN_MAX : pattern_length_ff;

   always_comb begin
      logic [LEN_W-1:0] idx;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         idx         = len_eff - LEN_W'(1) - LEN_W'(j);
         use_en[j]   = LEN_W'(j) < len_eff;
         pat_algn[j] = pat_vec[idx[3:0]*BYTE_W +: BYTE_W];
      end
   end

   // row of window cells; cell 0 sees the incoming byte
   assign chain[0] = req_tdata[BYTE_W-1:0];

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      sfa_cell u_cell (
         .clock       (clock),
         .shift_en    (accept),
         .data_in     (chain[j]),
         .pat_byte    (pat_algn[j]),
         .use_en      (use_en[j]),
         .ignore_case (ignore_case_ff),
         .data_out    (chain[j+1]),
         .eq_out      (eq[j])
      );
   end

   // match decision and counters for this byte
   always_comb begin
      seen_cur  = req_tuser ? '0 : bytes_seen_ff;
      pos_cur   = req_tuser ? start_position_ff : position_ff;
      count_cur = req_tuser ? '0 : counter_ff;
      seen      = seen_cur + LEN_W'(1);
      all_eq    = &eq;
      hit       = (len_eff != '0) && (seen >= len_eff) && (count_cur < match_limit_ff) && all_eq;
      count_new = count_cur + COUNT_W'(hit);
      match_pos = pos_cur - POS_W'(len_eff) + POS_W'(1);
      emit      = hit || req_tlast;

      result.found    = hit;
      result.position = hit ? match_pos : '0;
      result.count    = count_new;
      result.done     = req_tlast;

      if (req_tlast) begin
         bytes_seen_in = '0;
         position_in   = start_position_ff;
         counter_in    = '0;
      end else begin
         bytes_seen_in = (seen > LEN_MAX) ? LEN_MAX : seen;
         position_in   = pos_cur + POS_W'(1);
         counter_in    = count_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         position_ff   <= '0;
         counter_ff    <= '0;
      end else if (accept) begin
         bytes_seen_ff <= bytes_seen_in;
         position_ff   <= position_in;
         counter_ff    <= counter_in;
      end
   end

   // output buffer
   sfa_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && emit),
      .push_data (result),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign req_tready = space_ok;
   assign rsp_tdata  = {1'b0, out_data.count, out_data.position};
   assign rsp_tuser  = out_data.found;
   assign rsp_tlast  = out_data.done;

endmodule

>>> design/sfa_cell.sv
// one window cell: holds a text byte, passes it on and compares the byte it receives
module sfa_cell (
   input  logic                     clock,
   input  logic                     shift_en,
   input  logic [sfa_pkg::BYTE_W-1:0] data_in,
   input  logic [sfa_pkg::BYTE_W-1:0] pat_byte,
   input  logic                     use_en,
   input  logic                     ignore_case,
   output logic [sfa_pkg::BYTE_W-1:0] data_out,
   output logic                     eq_out
);
   import sfa_pkg::*;

   logic [BYTE_W-1:0] data_ff;

   // ascii uppercase to lowercase when folding is on
   function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b, input logic ic);
      logic [BYTE_W-1:0] r;
      r = b;
      if (ic && b >= 8'h41 && b <= 8'h5A) begin
         r = b ^ 8'h20;
      end
      return r;
   endfunction

   // shift the window byte on every accepted transfer
   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   // cells beyond the pattern length always agree
   assign eq_out   = !use_en || (fold(data_in, ignore_case) == fold(pat_byte, ignore_case));
   assign data_out = data_ff;

endmodule

>>> design/sfa_out_buf.sv
// two-entry output register with skid slot for the result stream
module sfa_out_buf (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  sfa_pkg::rsp_type             push_data,
   output logic                         space_ok,
   output logic                         out_valid,
   input  logic                         out_ready,
   output sfa_pkg::rsp_type             out_data
);
   import sfa_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;

   // refill the output slot from skid first, else from the new result; a result that cannot go there waits in skid
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign space_ok  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

>>> design/sfa_checker.sv
// port-level checks of the substring search result stream, bound to the top level
module sfa_port_checks (
   input logic                           clock,
   input logic                           reset,
   input logic [sfa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready
);
   import sfa_pkg::*;

   // a stalled result holds still
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a result without a match only comes at the end of a text, with zero position
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[POS_W-1:0] == '0))
      else $error("no-match result outside end of text");

   // a reported match counts at least itself
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[POS_W+COUNT_W-1:POS_W] != '0)
      else $error("match reported with zero count");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind substring_find_all sfa_port_checks u_sfa_port_checks (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
